// ===== hw/rtl/command_buffer_parser_macros.svh =====
// Assertion macros used by the checker file.
`ifndef COMMAND_BUFFER_PARSER_MACROS_SVH
`define COMMAND_BUFFER_PARSER_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define CBP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define CBP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/cbp_pkg.sv =====
package cbp_pkg;

   localparam int unsigned MAX_COMMANDS_DEFAULT = 255;

   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned CHAR_WIDTH  = 7;

   localparam logic [7:0] QUOTE_BYTE = 8'h27;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [6:0] SPACE_CHAR = 7'h20;
   localparam logic [6:0] DEL_CHAR   = 7'h7F;
   localparam logic [6:0] NUL_CHAR   = 7'h00;

   localparam logic [1:0] STATUS_PARSING = 2'd0;
   localparam logic [1:0] STATUS_VALID   = 2'd1;
   localparam logic [1:0] STATUS_CORRUPT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]  text_char;
      logic                   char_valid;
      logic                   command_end;
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] cmd_tally;
   } result_type;

endpackage

// ===== hw/rtl/cbp_if.sv =====
interface cbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cbp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cbp_pkg::CHAR_WIDTH-1:0]   text_char;
   logic                             char_valid;
   logic                             command_end;
   logic [1:0]                       status;
   logic [cbp_pkg::COUNT_WIDTH-1:0]  cmd_tally;

   modport source (output valid, output text_char, output char_valid, output command_end,
                   output status, output cmd_tally, input ready);
   modport sink   (input valid, input text_char, input char_valid, input command_end,
                   input status, input cmd_tally, output ready);
endinterface

// ===== hw/rtl/cbp_in_stage.sv =====
module cbp_in_stage (
   input  logic              clock,
   input  logic              reset,
   cbp_req_if.sink           req_if,
   input  logic              advance,
   output logic              item_valid,
   output cbp_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   cbp_pkg::item_type item_ff;
   logic              take;

   // Accept a new transaction whenever the stage is empty or drains this cycle.
   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.last_byte <= req_if.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/cbp_parser.sv =====
module cbp_parser #(
   parameter int unsigned MAX_COMMANDS = cbp_pkg::MAX_COMMANDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  cbp_pkg::item_type   item,
   output cbp_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_BETWEEN,
      PH_INSIDE,
      PH_DONE_OK,
      PH_DONE_BAD
   } phase_type;

   localparam logic [cbp_pkg::COUNT_WIDTH-1:0] COUNT_LIMIT =
      (MAX_COMMANDS > 255) ? 8'd255 : cbp_pkg::COUNT_WIDTH'(MAX_COMMANDS);

   phase_type                       phase_ff, phase_in;
   logic                            cut_ff, cut_in;
   logic                            bad_ff, bad_in;
   logic                            nonempty_ff, nonempty_in;
   logic [cbp_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      logic [6:0] masked;
      logic       closing;

      masked             = item.data_byte[6:0];
      closing            = 1'b0;
      phase_in           = phase_ff;
      cut_in             = cut_ff;
      bad_in             = bad_ff;
      nonempty_in        = nonempty_ff;
      count_in           = count_ff;
      result.text_char   = cbp_pkg::NUL_CHAR;
      result.char_valid  = 1'b0;
      result.command_end = 1'b0;
      result.status      = cbp_pkg::STATUS_PARSING;

      case (phase_ff)
         PH_DONE_OK: begin
            result.status = cbp_pkg::STATUS_VALID;
         end
         PH_DONE_BAD: begin
            result.status = cbp_pkg::STATUS_CORRUPT;
         end
         default: begin
            if (phase_ff == PH_BETWEEN) begin
               if (item.data_byte == cbp_pkg::ZERO_BYTE) begin
                  phase_in = PH_BETWEEN;
               end else if (item.data_byte == cbp_pkg::QUOTE_BYTE) begin
                  result.status = cbp_pkg::STATUS_VALID;
                  phase_in      = PH_DONE_OK;
               end else begin
                  phase_in = PH_INSIDE;
               end
            end

            if (phase_in == PH_INSIDE) begin
               if (item.data_byte == cbp_pkg::QUOTE_BYTE) begin
                  closing = 1'b1;
               end else begin
                  if (!cut_ff) begin
                     if (masked == cbp_pkg::NUL_CHAR) begin
                        cut_in = 1'b1;
                     end else begin
                        result.text_char  = masked;
                        result.char_valid = 1'b1;
                        nonempty_in       = 1'b1;
                        if (masked < cbp_pkg::SPACE_CHAR || masked == cbp_pkg::DEL_CHAR) begin
                           bad_in = 1'b1;
                        end
                     end
                  end
                  if (item.last_byte) begin
                     closing = 1'b1;
                  end
               end
            end

            // Judge the command that closes here, then clear its flags.
            if (closing) begin
               result.command_end = 1'b1;
               if (bad_in || !nonempty_in) begin
                  result.status = cbp_pkg::STATUS_CORRUPT;
                  phase_in      = PH_DONE_BAD;
               end else begin
                  if (count_ff < COUNT_LIMIT) begin
                     count_in = count_ff + 8'd1;
                  end
                  phase_in = PH_BETWEEN;
               end
               cut_in      = 1'b0;
               bad_in      = 1'b0;
               nonempty_in = 1'b0;
            end

            if (item.last_byte && result.status == cbp_pkg::STATUS_PARSING) begin
               result.status = cbp_pkg::STATUS_VALID;
            end
         end
      endcase

      result.cmd_tally = count_in;

      // Region end: drop back to the reset state for the next region.
      if (item.last_byte) begin
         phase_in    = PH_BETWEEN;
         cut_in      = 1'b0;
         bad_in      = 1'b0;
         nonempty_in = 1'b0;
         count_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_BETWEEN;
         cut_ff      <= 1'b0;
         bad_ff      <= 1'b0;
         nonempty_ff <= 1'b0;
         count_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         cut_ff      <= cut_in;
         bad_ff      <= bad_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== hw/rtl/command_buffer_parser.sv =====
// Command buffer parser.
// req_if carries the raw bytes of one command-buffer region in order; last_byte marks
// the final byte of the region. rsp_if returns exactly one result per byte: the command
// character with bit 7 cleared, its valid flag, the end-of-command flag, the buffer
// status (parsing, complete and valid, corrupt) and the saturating command count.
// Both channels move a transaction at a clock edge where valid and ready are high.
// A byte accepted on req_if is registered in the input stage, then evaluated and
// written to the result register as it advances; its result is offered from then on.
// Throughput: one byte per cycle unless rsp_if stalls; the parse step is a handful of
// byte compares and an 8-bit increment between the input register and the result register.
// When the receiver stalls, the result register holds; the input stage still takes one
// more transaction, then req_if.ready drops until the result is taken.
// After a byte with last_byte set, all parse state and the count return to reset values.
// Synchronous reset empties both stages and returns the parser to between-commands.
module command_buffer_parser #(
   parameter int unsigned MAX_COMMANDS = cbp_pkg::MAX_COMMANDS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cbp_req_if.sink   req_if,
   cbp_rsp_if.source rsp_if
);

   logic                item_valid;
   cbp_pkg::item_type   item;
   cbp_pkg::result_type result;
   logic                advance;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cbp_pkg::result_type rsp_data_ff;

   // Move the held byte forward when the result register is free or drains now.
   assign advance = item_valid && (!rsp_valid_ff || rsp_if.ready);

   cbp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   cbp_parser #(
      .MAX_COMMANDS (MAX_COMMANDS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.text_char   = rsp_data_ff.text_char;
   assign rsp_if.char_valid  = rsp_data_ff.char_valid;
   assign rsp_if.command_end = rsp_data_ff.command_end;
   assign rsp_if.status      = rsp_data_ff.status;
   assign rsp_if.cmd_tally   = rsp_data_ff.cmd_tally;

endmodule

// ===== hw/rtl/cbp_checker.sv =====
`include "command_buffer_parser_macros.svh"

module cbp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cbp_pkg::CHAR_WIDTH-1:0]  text_char,
   input logic                            char_valid,
   input logic                            command_end,
   input logic [1:0]                      status,
   input logic [cbp_pkg::COUNT_WIDTH-1:0] cmd_tally
);

   // No result may appear in the cycle after reset.
   `CBP_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)

   // A stalled result holds all of its fields.
   `CBP_ASSERT(a_stall_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(text_char) && $stable(char_valid) &&
      $stable(command_end) && $stable(status) && $stable(cmd_tally))

   // A dropped or absent character reads as zero.
   `CBP_ASSERT(a_char_zero, clock, reset,
      rsp_valid && !char_valid |-> text_char == cbp_pkg::NUL_CHAR)

   // A command closed while still parsing was accepted, so the count is nonzero when MAX_COMMANDS is nonzero.
   `CBP_ASSERT(a_count_on_close, clock, reset,
      rsp_valid && command_end && status == cbp_pkg::STATUS_PARSING |-> cmd_tally != 8'd0)

   // Status only takes its three defined codes.
   `CBP_ASSERT(a_status_code, clock, reset,
      rsp_valid |-> status == cbp_pkg::STATUS_PARSING || status == cbp_pkg::STATUS_VALID ||
      status == cbp_pkg::STATUS_CORRUPT)

endmodule

bind command_buffer_parser cbp_checker u_cbp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .text_char   (rsp_if.text_char),
   .char_valid  (rsp_if.char_valid),
   .command_end (rsp_if.command_end),
   .status      (rsp_if.status),
   .cmd_tally   (rsp_if.cmd_tally)
);
